// File: design/ip_blocklist_table_macros.svh
// Assertion macros shared by the ip_blocklist_table RTL.
// Expects clk and rst_n in scope at the point of use; no other dependencies.
`ifndef IP_BLOCKLIST_TABLE_MACROS_SVH
`define IP_BLOCKLIST_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define IBT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IBT_ASSERT(lbl, prop, msg)
`define IBT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/ibt_pkg.sv
// Package for the ip_blocklist_table block: field widths, op codes and the
// command/status structs between controller and datapath. No dependencies.
package ibt_pkg;

    localparam int MODE_W      = 2;
    localparam int ADDR_W      = 32;
    localparam int COUNT_OUT_W = 7;

    localparam logic [COUNT_OUT_W-1:0] COUNT_OUT_MAX = 7'd127;

    localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD   = 2'd3;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic clear_step;
        logic wr_entry;
        logic wr_valid;
        logic finish;
        logic ok;
    } ibt_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] op;
        logic              found;
        logic              exhausted;
        logic              clear_last;
    } ibt_stat_t;

endpackage

// File: design/ibt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ibt_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/ibt_ctrl.sv
// Controller for ip_blocklist_table: clear pass, entry scan, finish.
// Depends on ibt_pkg and ip_blocklist_table_macros.svh.
`include "ip_blocklist_table_macros.svh"
module ibt_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ibt_pkg::MODE_W-1:0]   mode,
    output logic                         busy,
    output ibt_pkg::ibt_cmd_t            cmd,
    input  ibt_pkg::ibt_stat_t           stat
);
    import ibt_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN} state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (mode)
                        MODE_CHECK, MODE_APPEND, MODE_REMOVE:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            cmd.finish = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.found)
                begin
                    cmd.finish   = 1'b1;
                    cmd.ok       = 1'b1;
                    cmd.wr_entry = (stat.op != MODE_CHECK);
                    cmd.wr_valid = (stat.op == MODE_APPEND);
                    state_next   = S_IDLE;
                end
                else if (stat.exhausted)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `IBT_ASSERT_NEXT(a_scan_after_start, start && !busy && mode != MODE_RSVD, state_reg == S_SCAN, "op word did not enter scan")

endmodule

// File: design/ibt_datapath.sv
// Datapath for ip_blocklist_table: entry RAM, scan index, compare, count, result.
// Depends on ibt_pkg, ibt_ram and ip_blocklist_table_macros.svh.
`include "ip_blocklist_table_macros.svh"
module ibt_datapath #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ibt_pkg::MODE_W-1:0]        mode,
    input  logic [ibt_pkg::ADDR_W-1:0]        ip_address,
    input  ibt_pkg::ibt_cmd_t                 cmd,
    output ibt_pkg::ibt_stat_t                stat,
    output logic                              done,
    output logic                              success,
    output logic [ibt_pkg::COUNT_OUT_W-1:0]   entries_in_use
);
    import ibt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ENT_W = ADDR_W + 1;

    localparam logic [CNT_W-1:0] N_ENTRIES = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] N_LAST    = CNT_W'(TABLE_ENTRIES - 1);
    localparam logic [31:0]      OUT_MAX_W = 32'(COUNT_OUT_MAX);

    logic [MODE_W-1:0]      op_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic                   data_vld_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   done_reg;
    logic                   success_reg;
    logic [COUNT_OUT_W-1:0] entries_in_use_reg;

    logic                   rd_en;
    logic [ENT_W-1:0]       rd_data;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [ENT_W-1:0]       wr_data;
    logic                   idx_more;
    logic                   rd_valid;
    logic [ADDR_W-1:0]      rd_addr_val;
    logic [31:0]            count_wide;

    assign idx_more    = (idx_reg < N_ENTRIES);
    assign rd_en       = cmd.scan_step && idx_more;
    assign rd_valid    = rd_data[ENT_W-1];
    assign rd_addr_val = rd_data[ADDR_W-1:0];

    assign wr_en   = cmd.clear_step || cmd.wr_entry;
    assign wr_addr = cmd.clear_step ? idx_reg[IDX_W-1:0] : cmp_idx_reg;
    assign wr_data = cmd.clear_step ? '0 : {cmd.wr_valid, addr_reg};

    ibt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // append looks for a free slot, check/remove for a live match
    always_comb
    begin
        stat.op         = op_reg;
        stat.found      = data_vld_reg &&
                          ((op_reg == MODE_APPEND) ? !rd_valid
                                                   : (rd_valid && rd_addr_val == addr_reg));
        stat.exhausted  = !data_vld_reg && (idx_reg == N_ENTRIES);
        stat.clear_last = (idx_reg == N_LAST);
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.wr_entry)
        begin
            count_next = cmd.wr_valid ? count_reg + CNT_W'(1) : count_reg - CNT_W'(1);
        end
        count_wide = 32'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= mode;
            addr_reg <= ip_address;
        end
        if (cmd.scan_step)
        begin
            cmp_idx_reg <= idx_reg[IDX_W-1:0];
        end
        if (cmd.finish)
        begin
            success_reg        <= cmd.ok;
            entries_in_use_reg <= (count_wide > OUT_MAX_W) ? COUNT_OUT_MAX
                                                           : count_wide[COUNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            data_vld_reg <= 1'b0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg      <= '0;
                data_vld_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                data_vld_reg <= idx_more;
                if (idx_more)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
            else if (cmd.clear_step)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            count_reg <= count_next;
            done_reg  <= cmd.finish;
        end
    end

    assign done           = done_reg;
    assign success        = success_reg;
    assign entries_in_use = entries_in_use_reg;

    `IBT_ASSERT(a_count_bound, count_reg <= N_ENTRIES, "used count above table size")
    `IBT_ASSERT(a_write_compared, !cmd.wr_entry || data_vld_reg, "entry write without compared slot")
    `IBT_ASSERT(a_remove_live, !(cmd.wr_entry && !cmd.wr_valid) || rd_valid, "remove of a free slot")

endmodule

// File: design/ip_blocklist_table.sv
// Top level of ip_blocklist_table: controller plus datapath.
// Depends on ibt_pkg, ibt_ctrl and ibt_datapath.
//
// After reset the block sweeps the entry RAM once to clear it, with busy
// high throughout. A word is taken when start is high and busy is low.
// Entries are read one per cycle from a single RAM read port, and a scan
// stops at the first hit: a live matching slot for a check or remove, the
// lowest free slot for an append; a miss or a full table scans every slot.
// Mode 3 is answered with no scan. The result shows on success and
// entries_in_use with done high for one cycle, in the cycle busy falls after
// a scan; it cannot be held, so the receiver must take it in that cycle.
module ip_blocklist_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ibt_pkg::MODE_W-1:0]        mode,
    input  logic [ibt_pkg::ADDR_W-1:0]        ip_address,
    output logic                              done,
    output logic                              success,
    output logic [ibt_pkg::COUNT_OUT_W-1:0]   entries_in_use
);
    import ibt_pkg::*;

    ibt_cmd_t  cmd;
    ibt_stat_t stat;

    ibt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    ibt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .mode           (mode),
        .ip_address     (ip_address),
        .cmd            (cmd),
        .stat           (stat),
        .done           (done),
        .success        (success),
        .entries_in_use (entries_in_use)
    );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for ip_blocklist_table: a directed table, a fill to capacity, then phased random
// fill/drain traffic; each result is checked against its typed verdict or a behavioral model.
// Depends on ibt_pkg and the ip_blocklist_table RTL.
module tb;
    import ibt_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    localparam int TOTAL_WORDS   = 1700;
    localparam int DRAIN_CYCLES  = TABLE_ENTRIES + 8;
    localparam int POOL_SIZE     = 8;

    typedef struct packed {
        logic                   success;
        logic [COUNT_OUT_W-1:0] count;
    } verdict_t;

    typedef struct packed {
        logic [MODE_W-1:0]      op;
        logic [ADDR_W-1:0]      addr;
        logic                   typed;
        logic                   success;
        logic [COUNT_OUT_W-1:0] count;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [MODE_W-1:0]      mode;
    logic [ADDR_W-1:0]      ip_address;
    logic                   done;
    logic                   success;
    logic [COUNT_OUT_W-1:0] entries_in_use;

    ip_blocklist_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .ip_address     (ip_address),
        .done           (done),
        .success        (success),
        .entries_in_use (entries_in_use)
    );

    // shadow copy of the table
    logic [ADDR_W-1:0] shadow_addr [TABLE_ENTRIES];
    logic              shadow_valid [TABLE_ENTRIES];
    int                shadow_used;

    verdict_t          pending_verdicts [$];
    verdict_t          predicted;
    verdict_t          oldest;

    logic              typed_valid;
    verdict_t          typed_verdict;

    int mismatches;
    int words_taken;
    int check_hits;
    int full_rejects;
    int remove_misses;
    int remove_hits;
    int reserved_words;

    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    stim_row_t directed_rows [15] = '{
        '{MODE_CHECK,  32'h0000_0000, 1'b1, 1'b0, 7'd0},
        '{MODE_REMOVE, 32'hFFFF_FFFF, 1'b1, 1'b0, 7'd0},
        '{MODE_RSVD,   32'hA5A5_A5A5, 1'b1, 1'b0, 7'd0},
        '{MODE_APPEND, 32'h0000_0000, 1'b1, 1'b1, 7'd1},
        '{MODE_APPEND, 32'hFFFF_FFFF, 1'b1, 1'b1, 7'd2},
        '{MODE_CHECK,  32'h0000_0000, 1'b1, 1'b1, 7'd2},
        '{MODE_CHECK,  32'hFFFF_FFFF, 1'b1, 1'b1, 7'd2},
        '{MODE_APPEND, 32'hFFFF_FFFF, 1'b0, 1'b0, 7'd0},
        '{MODE_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0, 7'd0},
        '{MODE_CHECK,  32'hFFFF_FFFF, 1'b0, 1'b0, 7'd0},
        '{MODE_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0, 7'd0},
        '{MODE_CHECK,  32'hFFFF_FFFF, 1'b0, 1'b0, 7'd0},
        '{MODE_RSVD,   32'h5A5A_5A5A, 1'b0, 1'b0, 7'd0},
        '{MODE_REMOVE, 32'h8000_0000, 1'b0, 1'b0, 7'd0},
        '{MODE_CHECK,  32'h7FFF_FFFF, 1'b0, 1'b0, 7'd0}
    };

    function automatic int find_entry(logic [ADDR_W-1:0] addr);
        for (int k = 0; k < TABLE_ENTRIES; k++)
            if (shadow_valid[k] && shadow_addr[k] == addr)
                return k;
        return -1;
    endfunction

    function automatic verdict_t apply_blocklist_op(logic [MODE_W-1:0] op,
                                                    logic [ADDR_W-1:0] addr);
        verdict_t v;
        int       slot;
        v.success = 1'b0;
        slot = -1;
        case (op)
            MODE_CHECK:
                v.success = (find_entry(addr) >= 0);
            MODE_APPEND:
            begin
                for (int k = TABLE_ENTRIES - 1; k >= 0; k--)
                    if (!shadow_valid[k])
                        slot = k;
                if (slot >= 0)
                begin
                    shadow_addr[slot]  = addr;
                    shadow_valid[slot] = 1'b1;
                    shadow_used++;
                    v.success = 1'b1;
                end
            end
            MODE_REMOVE:
            begin
                slot = find_entry(addr);
                if (slot >= 0)
                begin
                    shadow_valid[slot] = 1'b0;
                    if (shadow_used > 0)
                        shadow_used--;
                    v.success = 1'b1;
                end
            end
            default:
                v.success = 1'b0;
        endcase
        v.count = (shadow_used > int'(COUNT_OUT_MAX)) ? COUNT_OUT_MAX
                                                      : COUNT_OUT_W'(shadow_used);
        return v;
    endfunction

    task automatic flag_mismatch(string what, verdict_t want);
        if (mismatches < 10)
            $display("%0t: %s: expected success=%0b entries=%0d, got success=%0b entries=%0d",
                     $realtime, what, want.success, want.count, success, entries_in_use);
        mismatches++;
    endtask

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result check first, then record the word taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_verdicts.size() == 0)
                    flag_mismatch("unexpected result word", '0);
                else
                begin
                    oldest = pending_verdicts.pop_front();
                    if (success !== oldest.success || entries_in_use !== oldest.count)
                        flag_mismatch("result mismatch", oldest);
                end
            end
            if (start && !busy)
            begin
                predicted = apply_blocklist_op(mode, ip_address);
                pending_verdicts.push_back(typed_valid ? typed_verdict : predicted);
                words_taken++;
                case (mode)
                    MODE_CHECK:  check_hits    += predicted.success;
                    MODE_APPEND: full_rejects  += !predicted.success;
                    MODE_REMOVE:
                    begin
                        remove_hits   += predicted.success;
                        remove_misses += !predicted.success;
                    end
                    default:     reserved_words++;
                endcase
            end
        end
    end

    task automatic issue_word(logic [MODE_W-1:0] op, logic [ADDR_W-1:0] addr,
                              logic typed, verdict_t want, int gap);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start         = 1'b1;
        mode          = op;
        ip_address    = addr;
        typed_valid   = typed;
        typed_verdict = want;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_address(int live_pct, int pool_pct);
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < live_pct && shadow_used > 0)
        begin
            k = $urandom_range(0, TABLE_ENTRIES - 1);
            while (!shadow_valid[k])
                k = (k + 1) % TABLE_ENTRIES;
            return shadow_addr[k];
        end
        if (r < live_pct + pool_pct)
            return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    initial
    begin
        logic [MODE_W-1:0] op;
        logic [ADDR_W-1:0] addr;
        int                issued;
        int                r;
        logic              filling;
        int                idle_style;
        int                at_limit;
        int                limit_len;
        int                phases;

        start         = 1'b0;
        mode          = MODE_CHECK;
        ip_address    = '0;
        typed_valid   = 1'b0;
        typed_verdict = '0;
        rst_n         = 1'b0;
        shadow_used   = 0;
        mismatches    = 0;
        words_taken   = 0;
        check_hits    = 0;
        full_rejects  = 0;
        remove_misses = 0;
        remove_hits   = 0;
        reserved_words = 0;
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            shadow_addr[k]  = '0;
            shadow_valid[k] = 1'b0;
        end
        for (int k = 0; k < POOL_SIZE; k++)
            addr_pool[k] = $urandom;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        issued = 0;
        foreach (directed_rows[i])
        begin
            issue_word(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].typed,
                       '{directed_rows[i].success, directed_rows[i].count},
                       $urandom_range(0, 11));
            issued++;
        end

        // fill to capacity, then append once more into a full table
        while (shadow_used < TABLE_ENTRIES)
        begin
            issue_word(MODE_APPEND, $urandom, 1'b0, '0, $urandom_range(0, 3) == 0 ?
                       $urandom_range(0, 11) : 0);
            issued++;
        end
        issue_word(MODE_APPEND, 32'hDEAD_BEEF, 1'b1, '{1'b0, 7'd64}, 0);
        issued++;

        // hold off until the table has answered everything
        start = 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);

        filling    = 1'b0;
        idle_style = 0;
        at_limit   = 0;
        limit_len  = 4;
        phases     = 0;
        while (issued < TOTAL_WORDS)
        begin
            if (at_limit >= limit_len || $urandom_range(0, 199) == 0)
            begin
                filling    = !filling;
                idle_style = $urandom_range(0, 2);
                at_limit   = 0;
                limit_len  = $urandom_range(2, 8);
                phases++;
            end
            r = $urandom_range(0, 99);
            if (filling)
                op = (r < 55) ? MODE_APPEND : (r < 75) ? MODE_CHECK :
                     (r < 94) ? MODE_REMOVE : MODE_RSVD;
            else
                op = (r < 55) ? MODE_REMOVE : (r < 75) ? MODE_CHECK :
                     (r < 95) ? MODE_APPEND : MODE_RSVD;
            case (op)
                MODE_APPEND: addr = pick_address(0, 30);
                MODE_REMOVE: addr = pick_address(80, 10);
                MODE_CHECK:  addr = pick_address(50, 20);
                default:     addr = $urandom;
            endcase
            issue_word(op, addr, 1'b0, '0, idle_style == 0 ? 0 : $urandom_range(0, 11));
            issued++;
            if ((filling && shadow_used == TABLE_ENTRIES) || (!filling && shadow_used == 0))
                at_limit++;
        end

        start = 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d words over %0d fill/drain phases: %0d check hits, %0d removes,",
                 words_taken, phases, check_hits, remove_hits);
        $display("%0d remove misses, %0d full-table appends, %0d unused-mode words, %0d mismatches",
                 remove_misses, full_rejects, reserved_words, mismatches);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
